// ===== rtl/core/lbbp_pkg.sv =====
`default_nettype none

package lbbp_pkg;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned ValueBits  = 64;
  localparam int unsigned StreamBits = ValueBits + ByteBits;
  localparam int unsigned CountBits  = 9;

  localparam logic FuncValue = 1'b0;
  localparam logic FuncZeros = 1'b1;

  typedef struct packed {
    logic load;
    logic emit;
  } lbbp_cmd_t;

  typedef struct packed {
    logic multi;
    logic last;
  } lbbp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/lbbp_ctrl.sv =====
`default_nettype none

module lbbp_ctrl
  import lbbp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire lbbp_sts_t sts_i,
  output lbbp_cmd_t      cmd_o
);

  typedef enum logic {
    StIdle,
    StEmit
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = (state_q == StIdle) && in_valid_i;
  assign cmd_o.emit  = (state_q == StEmit) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cmd_o.load && sts_i.multi) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (cmd_o.emit && sts_i.last) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lbbp_dp.sv =====
`default_nettype none

module lbbp_dp
  import lbbp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 func_i,
  input  wire logic [7:0]           bit_count_i,
  input  wire logic [ValueBits-1:0] field_value_i,
  input  wire lbbp_cmd_t            cmd_i,
  output lbbp_sts_t                 sts_o,
  output logic [ByteBits-1:0]       out_byte_o,
  output logic                      last_o
);

  logic [ByteBits-1:0]   pend_bits_q;
  logic [2:0]            pend_cnt_q;
  logic [StreamBits-1:0] stream_q;
  logic [CountBits-1:0]  rem_q;
  logic [ByteBits-1:0]   obyte_q;
  logic                  olast_q;

  logic [CountBits-1:0]  width_eff;
  logic [CountBits-1:0]  total;
  logic [ValueBits-1:0]  val_masked;
  logic [StreamBits-1:0] stream_d;

  always_comb begin
    if (func_i == FuncValue && bit_count_i[7:6] != 2'b00) begin
      width_eff = CountBits'(ValueBits);
    end else begin
      width_eff = CountBits'(bit_count_i);
    end
    if (bit_count_i[7:6] != 2'b00) begin
      val_masked = field_value_i;
    end else begin
      val_masked = field_value_i & ((ValueBits'(1) << bit_count_i[5:0]) - ValueBits'(1));
    end
    total = CountBits'(pend_cnt_q) + width_eff;
    if (func_i == FuncZeros) begin
      stream_d = StreamBits'(pend_bits_q);
    end else begin
      stream_d = (StreamBits'(val_masked) << pend_cnt_q) | StreamBits'(pend_bits_q);
    end
  end

  assign sts_o.multi = (total[CountBits-1:3] != '0);
  assign sts_o.last  = (rem_q[CountBits-1:4] == '0);
  assign out_byte_o  = obyte_q;
  assign last_o      = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      rem_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        pend_cnt_q <= total[2:0];
        rem_q      <= total;
        if (!sts_o.multi) begin
          pend_bits_q <= stream_d[ByteBits-1:0];
        end
      end else if (cmd_i.emit) begin
        rem_q <= rem_q - CountBits'(ByteBits);
        if (sts_o.last) begin
          pend_bits_q <= stream_q[2*ByteBits-1:ByteBits];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stream_q <= stream_d;
    end else if (cmd_i.emit) begin
      stream_q <= stream_q >> ByteBits;
      obyte_q  <= stream_q[ByteBits-1:0];
      olast_q  <= sts_o.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lsb_first_bitfield_byte_packer.sv =====
// Packs variable-width bit fields into a byte stream, least significant bit first.
// Input channel (in_valid_i/in_ready_o) carries func_i, bit_count_i and field_value_i.
// A value transaction appends the low bit_count_i bits of field_value_i, at most 64.
// A zero-run transaction appends bit_count_i zero bits.
// Output channel (out_valid_o/out_ready_i) carries one byte per transaction;
// last_o marks the final byte caused by an input transaction.
// An input is accepted when the packer is idle; its bytes then leave through the
// output register one per cycle unless the receiver stalls, and the input side
// stays busy until the final byte is emitted. The rate is set by the single byte
// shift register in the datapath, which emits one byte per cycle when not stalled.
// An input that completes no byte only updates the pending bits and leaves the
// packer idle. The next input is taken while the final byte still waits in the
// output register.
// When the receiver stalls, the output register holds its byte and the shift
// register waits. Reset clears the pending bits and count and empties the output.
`default_nettype none

module lsb_first_bitfield_byte_packer
  import lbbp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 func_i,
  input  wire logic [7:0]           bit_count_i,
  input  wire logic [ValueBits-1:0] field_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [ByteBits-1:0]       out_byte_o,
  output logic                      last_o
);

  lbbp_cmd_t cmd;
  lbbp_sts_t sts;

  lbbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lbbp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (func_i),
    .bit_count_i   (bit_count_i),
    .field_value_i (field_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd.load && cmd.emit))
    else $error("Load and emit issued in the same cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && sts.last |=> in_ready_o && out_valid_o && last_o)
    else $error("Final byte did not return the packer to idle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load && !sts.multi |=> in_ready_o)
    else $error("Transaction without a full byte left the packer busy.");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_lsb_first_bitfield_byte_packer.sv =====
module tb_lsb_first_bitfield_byte_packer;
  timeunit 1ns;
  timeprecision 1ps;

  import lbbp_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned RandomItems = 360;
  localparam int unsigned DirRowCount = 23;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  typedef struct packed {
    logic        fn;
    logic [7:0]  cnt;
    logic [63:0] val;
    logic        typed;
    logic [5:0]  n;
    logic [7:0]  b;
  } stim_row_t;

  typedef enum logic [1:0] {
    RxOpen,
    RxCoin,
    RxPeriodic,
    RxSparse
  } rx_mode_e;

  // Rows marked as typed start from a byte-aligned state, so the bytes are
  // known outright: n copies of the same byte value.
  localparam stim_row_t DirRows [DirRowCount] = '{
    '{FuncValue, 8'd8,   64'hFFFF_FFFF_FFFF_FFA5, 1'b1, 6'd1,  8'hA5},
    '{FuncValue, 8'd0,   AllOnes,                 1'b1, 6'd0,  8'h00},
    '{FuncZeros, 8'd0,   AllOnes,                 1'b1, 6'd0,  8'h00},
    '{FuncValue, 8'd64,  AllOnes,                 1'b1, 6'd8,  8'hFF},
    '{FuncValue, 8'd255, AllOnes,                 1'b1, 6'd8,  8'hFF},
    '{FuncValue, 8'd65,  64'h0,                   1'b1, 6'd8,  8'h00},
    '{FuncValue, 8'd3,   64'h5,                   1'b0, 6'd0,  8'h00},
    '{FuncZeros, 8'd2,   AllOnes,                 1'b0, 6'd0,  8'h00},
    '{FuncValue, 8'd11,  64'h7FF,                 1'b0, 6'd0,  8'h00},
    '{FuncValue, 8'd1,   64'h1,                   1'b0, 6'd0,  8'h00},
    '{FuncZeros, 8'd255, 64'h0,                   1'b0, 6'd0,  8'h00},
    '{FuncZeros, 8'd255, AllOnes,                 1'b1, 6'd31, 8'h00},
    '{FuncValue, 8'd1,   64'h1,                   1'b0, 6'd0,  8'h00},
    '{FuncZeros, 8'd8,   64'h0,                   1'b1, 6'd1,  8'h00},
    '{FuncValue, 8'd63,  AllOnes,                 1'b0, 6'd0,  8'h00},
    '{FuncValue, 8'd64,  64'h8000_0000_0000_0001, 1'b0, 6'd0,  8'h00},
    '{FuncValue, 8'd7,   64'h0,                   1'b0, 6'd0,  8'h00},
    '{FuncZeros, 8'd1,   64'h0,                   1'b0, 6'd0,  8'h00},
    '{FuncZeros, 8'd7,   64'h0,                   1'b0, 6'd0,  8'h00},
    '{FuncValue, 8'd32,  64'hDEAD_BEEF_CAFE_F00D, 1'b0, 6'd0,  8'h00},
    '{FuncValue, 8'd33,  64'h0123_4567_89AB_CDEF, 1'b0, 6'd0,  8'h00},
    '{FuncZeros, 8'd128, 64'h0,                   1'b0, 6'd0,  8'h00},
    '{FuncValue, 8'd128, 64'hAAAA_5555_AAAA_5555, 1'b0, 6'd0,  8'h00}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = FuncValue;
  logic [7:0]  bit_count_i = 8'd0;
  logic [63:0] field_value_i = 64'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_o;

  logic        row_typed = 1'b0;
  logic [5:0]  row_n = 6'd0;
  logic [7:0]  row_byte = 8'd0;

  logic [7:0]   pend_bits = 8'd0;
  int unsigned  pend_cnt = 0;
  logic [7:0]   pack_buf [32];
  int unsigned  pack_n;
  packed_byte_t exp_bytes_q [$];
  packed_byte_t head_byte;
  int unsigned  fail_cnt = 0;
  int unsigned  burst_left = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  k;

  rx_mode_e     rx_mode = RxOpen;
  int unsigned  rx_mode_left = 0;
  int unsigned  rx_phase = 0;

  lsb_first_bitfield_byte_packer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .bit_count_i  (bit_count_i),
    .field_value_i(field_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic predict_packed_bytes(input logic fn, input logic [7:0] cnt,
                                      input logic [63:0] val);
    int unsigned w;
    int unsigned take;
    int unsigned room;
    logic [63:0] v;
    pack_n = 0;
    v = val;
    if (fn == FuncValue) begin
      w = (cnt > 8'd64) ? 64 : int'(cnt);
      if (w < 64) v = v & ((64'd1 << w) - 64'd1);
      while (w + pend_cnt >= 8) begin
        take = 8 - pend_cnt;
        pack_buf[pack_n] = pend_bits | 8'(v << pend_cnt);
        pack_n++;
        w -= take;
        v = v >> take;
        pend_bits = 8'd0;
        pend_cnt = 0;
      end
      if (w != 0) begin
        pend_bits = pend_bits | 8'(v << pend_cnt);
        pend_cnt += w;
      end
    end else begin
      w = int'(cnt);
      if (pend_cnt != 0) begin
        room = 8 - pend_cnt;
        if (w < room) begin
          pend_cnt += w;
          w = 0;
        end else begin
          w -= room;
          pack_buf[pack_n] = pend_bits;
          pack_n++;
          pend_bits = 8'd0;
          pend_cnt = 0;
        end
      end
      while (w >= 8) begin
        pack_buf[pack_n] = 8'd0;
        pack_n++;
        w -= 8;
      end
      if (w != 0) begin
        pend_bits = 8'd0;
        pend_cnt = w;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_packed_bytes(func_i, bit_count_i, field_value_i);
      if (row_typed) begin
        pack_n = row_n;
        for (k = 0; k < pack_n; k++) pack_buf[k] = row_byte;
      end
      for (k = 0; k < pack_n; k++) begin
        exp_bytes_q.push_back('{pack_buf[k], (k == pack_n - 1)});
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_bytes_q.size() == 0) begin
        $error("out_byte: unexpected transaction, actual 0x%02h", out_byte_o);
        fail_cnt++;
      end else begin
        head_byte = exp_bytes_q.pop_front();
        if (out_byte_o !== head_byte.data) begin
          $error("out_byte: expected 0x%02h, actual 0x%02h", head_byte.data, out_byte_o);
          fail_cnt++;
        end
        if (last_o !== head_byte.last) begin
          $error("last: expected %0b, actual %0b", head_byte.last, last_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(20, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    rx_phase <= (rx_phase == 4) ? 0 : rx_phase + 1;
    case (rx_mode)
      RxOpen:     out_ready_i <= 1'b1;
      RxCoin:     out_ready_i <= ($urandom_range(0, 1) == 1);
      RxPeriodic: out_ready_i <= (rx_phase != 0);
      default:    out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic fn, input logic [7:0] cnt, input logic [63:0] val,
                           input logic typed, input logic [5:0] n, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    bit_count_i   <= cnt;
    field_value_i <= val;
    row_typed     <= typed;
    row_n         <= n;
    row_byte      <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    int unsigned i;
    int unsigned sel;
    logic        fn;
    logic [7:0]  cnt;
    logic [63:0] val;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < DirRowCount; i++) begin
      send_item(DirRows[i].fn, DirRows[i].cnt, DirRows[i].val,
                DirRows[i].typed, DirRows[i].n, DirRows[i].b);
    end
    for (i = 0; i < RandomItems; i++) begin
      fn = ($urandom_range(0, 99) < 60) ? FuncValue : FuncZeros;
      sel = $urandom_range(0, 99);
      if (fn == FuncValue) begin
        if (sel < 70) cnt = 8'($urandom_range(0, 64));
        else if (sel < 88) cnt = 8'($urandom_range(1, 8));
        else cnt = 8'($urandom_range(65, 255));
      end else begin
        if (sel < 70) cnt = 8'($urandom_range(0, 16));
        else if (sel < 90) cnt = 8'($urandom_range(17, 64));
        else cnt = 8'($urandom_range(65, 255));
      end
      sel = $urandom_range(0, 99);
      if (sel < 85) val = {$urandom(), $urandom()};
      else if (sel < 90) val = AllOnes;
      else if (sel < 95) val = 64'd0;
      else val = 64'd1 << $urandom_range(0, 63);
      send_item(fn, cnt, val, 1'b0, 6'd0, 8'd0);
    end
    in_valid_i <= 1'b0;
    while (exp_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && exp_bytes_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
